/* sv/etwa_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// etwa_pkg
// Shared types and constants of the episode table with aging.
// ----------------------------------------------------------------------------
package etwa_pkg;

    localparam int TABLE_DEPTH = 32;
    localparam int RESULT_CAP  = 32;

    localparam logic [47:0] RESOLVE_RESET = 48'd1000000;
    localparam logic [47:0] EXPIRE_RESET  = 48'd10000000;
    localparam logic [5:0]  LIMIT_RESET   = 6'd32;

    localparam logic [1:0] REG_RESOLVE = 2'd0;
    localparam logic [1:0] REG_EXPIRE  = 2'd1;
    localparam logic [1:0] REG_LIMIT   = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_INVALID  = 2'd1;
    localparam logic [1:0] ST_NO_MECH  = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    localparam logic [2:0] KIND_OPENED      = 3'd0;
    localparam logic [2:0] KIND_UPDATED     = 3'd1;
    localparam logic [2:0] KIND_ESCALATED   = 3'd2;
    localparam logic [2:0] KIND_DEESCALATED = 3'd3;
    localparam logic [2:0] KIND_QUIESCED    = 3'd4;
    localparam logic [2:0] KIND_RESOLVED    = 3'd5;
    localparam logic [2:0] KIND_EXPIRED     = 3'd6;
    localparam logic [2:0] KIND_UNCHANGED   = 3'd7;

    localparam logic [1:0] PH_OPEN      = 2'd0;
    localparam logic [1:0] PH_QUIESCENT = 2'd1;
    localparam logic [1:0] PH_RESOLVED  = 2'd2;
    localparam logic [1:0] PH_EXPIRED   = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_APPLY,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        M_ADV,
        M_QUI,
        M_ASSERT
    } t_mode;

    typedef struct packed {
        logic        valid;
        logic [63:0] key;
        logic [15:0] scope;
        logic [1:0]  phase;
        logic [2:0]  severity;
        logic [31:0] revision;
        logic [47:0] seen_at;
        logic [47:0] updated_at;
    } t_entry;

    typedef struct packed {
        logic [1:0]  status;
        logic [2:0]  kind;
        logic [63:0] id;
        logic [1:0]  phase;
        logic [31:0] revision;
        logic [2:0]  severity;
        logic        created;
    } t_res;

    function automatic t_res error_res(logic [1:0] st);
        t_res r;
        r        = '0;
        r.status = st;
        r.kind   = KIND_UNCHANGED;
        return r;
    endfunction

endpackage
`default_nettype wire

/* sv/episode_table_with_aging_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// episode_table_with_aging_unit
// Keyed episode table with idle aging, built as a ring of slot cells.
// ----------------------------------------------------------------------------
// The slots sit in a ring of cells that rotates by one each cycle of a scan or
// update pass, so every slot passes the head logic once per pass. An advance
// or a non-asserted observation takes one pass; an asserted observation takes a
// lookup pass and, unless it is refused as full, an update pass; an observation
// rejected on its fields takes no pass. Results appear on o_done for one cycle
// each and must be taken as they come; an advance may give up to 32 of them,
// the last one after its pass ends.
module episode_table_with_aging_unit #(
    parameter int TABLE_DEPTH = etwa_pkg::TABLE_DEPTH
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         start,
    output logic        busy,
    input  wire         i_req_type,
    input  wire  [47:0] i_now,
    input  wire  [63:0] i_episode_key,
    input  wire  [15:0] i_scope_id,
    input  wire         i_congestion_asserted,
    input  wire  [3:0]  i_mechanism,
    input  wire  [2:0]  i_severity,
    output logic        o_done,
    output logic [1:0]  o_status,
    output logic [2:0]  o_update_kind,
    output logic [63:0] o_entry_id,
    output logic [1:0]  o_result_phase,
    output logic [31:0] o_result_revision,
    output logic [2:0]  o_result_severity,
    output logic        o_created,
    output logic [31:0] o_dropped_total,
    output logic        o_last_of_run,
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [4:0]  paddr,
    input  wire  [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    localparam int IW  = $clog2(TABLE_DEPTH);
    localparam int CW  = $clog2(TABLE_DEPTH + 1);
    localparam int LW  = (CW > 6) ? CW : 6;
    localparam int RW  = $clog2(etwa_pkg::RESULT_CAP + 1);

    etwa_pkg::t_entry cell_q [TABLE_DEPTH];
    etwa_pkg::t_entry head_in;
    etwa_pkg::t_entry head_out;
    logic             shift;

    etwa_pkg::t_state r_state, n_state;
    etwa_pkg::t_mode  r_mode;
    logic [IW-1:0]    r_pos;
    logic [47:0]      r_now;
    logic [63:0]      r_key;
    logic [15:0]      r_scope;
    logic [2:0]       r_sev;

    logic [47:0] r_resolve;
    logic [47:0] r_expire;
    logic [5:0]  r_limit;
    logic [31:0] r_dropped;

    logic          r_hit_found, r_vic_found, r_free_found;
    logic [IW-1:0] r_hit_idx, r_vic_idx, r_free_idx;
    logic [47:0]   r_vic_lu;
    logic [CW-1:0] r_cnt;
    logic [RW-1:0] r_nres;

    logic          r_tgt_hit;
    logic [IW-1:0] r_tgt;
    logic          r_clr_en;
    logic [IW-1:0] r_clr_idx;

    etwa_pkg::t_res r_pend;
    logic           r_pend_valid;
    etwa_pkg::t_res r_o;
    logic           r_o_valid, n_o_valid;
    logic           r_o_last;
    logic [31:0]    r_o_dropped;

    logic           accept;
    logic           rejected;
    logic           cfg_wr;
    logic           pos_last;
    etwa_pkg::t_res hres;
    logic           hres_valid;
    logic [47:0]    idle;
    logic [48:0]    twice;
    logic [LW-1:0]  lim;
    logic           d_refuse;
    logic           d_drop;
    logic           d_create;
    logic [IW-1:0]  d_tgt;
    logic           d_clr_en;

    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_ring
        etwa_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (shift),
            .i_entry ((g == TABLE_DEPTH - 1) ? head_out : cell_q[(g + 1) % TABLE_DEPTH]),
            .o_entry (cell_q[g])
        );
    end

    assign head_in  = cell_q[0];
    assign shift    = (r_state == etwa_pkg::S_SCAN) || (r_state == etwa_pkg::S_APPLY);
    assign pos_last = (r_pos == IW'(TABLE_DEPTH - 1));
    assign busy     = (r_state != etwa_pkg::S_IDLE);
    assign accept   = start && !busy;
    assign rejected = !i_req_type && (i_scope_id == 16'd0 ||
                      (i_congestion_asserted && i_mechanism == 4'd0));
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign pready   = 1'b1;

    assign n_o_valid = ((r_state == etwa_pkg::S_IDLE) && accept && rejected) ||
                       ((r_state == etwa_pkg::S_SCAN) && (r_mode == etwa_pkg::M_ADV) &&
                        hres_valid && r_pend_valid) ||
                       ((r_state == etwa_pkg::S_DONE) &&
                        (r_pend_valid || r_mode != etwa_pkg::M_ADV));

    always_comb begin
        case (paddr[4:3])
            etwa_pkg::REG_RESOLVE: prdata = {16'd0, r_resolve};
            etwa_pkg::REG_EXPIRE:  prdata = {16'd0, r_expire};
            etwa_pkg::REG_LIMIT:   prdata = {58'd0, r_limit};
            default:               prdata = 64'd0;
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            etwa_pkg::S_IDLE: begin
                if (accept && !rejected) begin
                    n_state = etwa_pkg::S_SCAN;
                end
            end
            etwa_pkg::S_SCAN: begin
                if (pos_last) begin
                    n_state = (r_mode == etwa_pkg::M_ASSERT) ? etwa_pkg::S_DECIDE
                                                             : etwa_pkg::S_DONE;
                end
            end
            etwa_pkg::S_DECIDE: begin
                n_state = d_refuse ? etwa_pkg::S_DONE : etwa_pkg::S_APPLY;
            end
            etwa_pkg::S_APPLY: begin
                if (pos_last) begin
                    n_state = etwa_pkg::S_DONE;
                end
            end
            etwa_pkg::S_DONE: begin
                n_state = etwa_pkg::S_IDLE;
            end
            default: n_state = etwa_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        head_out   = head_in;
        hres       = '0;
        hres_valid = 1'b0;
        idle       = r_now - head_in.seen_at;
        twice      = {r_resolve, 1'b0};
        lim        = LW'(r_limit);
        d_refuse   = 1'b0;
        d_drop     = 1'b0;
        d_create   = 1'b0;
        d_tgt      = r_hit_idx;
        d_clr_en   = 1'b0;
        if (r_limit == 6'd0) begin
            lim = LW'(1);
        end else if (lim > LW'(TABLE_DEPTH)) begin
            lim = LW'(TABLE_DEPTH);
        end
        case (r_state)
            etwa_pkg::S_SCAN: begin
                if (r_mode == etwa_pkg::M_ADV) begin
                    if (head_in.valid && r_now >= head_in.seen_at &&
                        r_nres < RW'(etwa_pkg::RESULT_CAP)) begin
                        if (head_in.phase == etwa_pkg::PH_OPEN && idle > r_resolve) begin
                            head_out.phase = etwa_pkg::PH_QUIESCENT;
                            hres_valid     = 1'b1;
                        end else if (head_in.phase == etwa_pkg::PH_QUIESCENT &&
                                     {1'b0, idle} > twice) begin
                            head_out.phase = etwa_pkg::PH_RESOLVED;
                            hres_valid     = 1'b1;
                        end else if ((head_in.phase == etwa_pkg::PH_QUIESCENT ||
                                      head_in.phase == etwa_pkg::PH_RESOLVED) &&
                                     idle > r_expire) begin
                            head_out.phase = etwa_pkg::PH_EXPIRED;
                            hres_valid     = 1'b1;
                        end
                        if (hres_valid) begin
                            head_out.updated_at = r_now;
                            head_out.revision   = head_in.revision + 32'd1;
                            if (head_out.phase != etwa_pkg::PH_QUIESCENT) begin
                                head_out.severity = 3'd0;
                            end
                            hres.kind = (head_out.phase == etwa_pkg::PH_QUIESCENT) ?
                                        etwa_pkg::KIND_QUIESCED :
                                        (head_out.phase == etwa_pkg::PH_RESOLVED) ?
                                        etwa_pkg::KIND_RESOLVED : etwa_pkg::KIND_EXPIRED;
                        end
                    end
                end else if (r_mode == etwa_pkg::M_QUI) begin
                    if (head_in.valid && head_in.scope == r_scope &&
                        head_in.phase == etwa_pkg::PH_OPEN) begin
                        head_out.phase      = etwa_pkg::PH_QUIESCENT;
                        head_out.severity   = 3'd0;
                        head_out.updated_at = r_now;
                        head_out.revision   = head_in.revision + 32'd1;
                        hres.kind           = etwa_pkg::KIND_QUIESCED;
                        hres_valid          = 1'b1;
                    end
                end
            end
            etwa_pkg::S_DECIDE: begin
                if (!r_hit_found) begin
                    if (LW'(r_cnt) >= lim) begin
                        d_drop = 1'b1;
                        if (r_vic_found) begin
                            d_create = 1'b1;
                            d_tgt    = (r_free_found && r_free_idx < r_vic_idx) ?
                                       r_free_idx : r_vic_idx;
                            d_clr_en = (d_tgt != r_vic_idx);
                        end else begin
                            d_refuse = 1'b1;
                        end
                    end else if (r_free_found) begin
                        d_create = 1'b1;
                        d_tgt    = r_free_idx;
                    end else begin
                        d_refuse = 1'b1;
                    end
                end
            end
            etwa_pkg::S_APPLY: begin
                if (r_pos == r_tgt) begin
                    head_out.phase      = etwa_pkg::PH_OPEN;
                    head_out.severity   = r_sev;
                    head_out.seen_at    = r_now;
                    head_out.updated_at = r_now;
                    hres_valid          = 1'b1;
                    if (r_tgt_hit) begin
                        head_out.revision = head_in.revision + 32'd1;
                        if (head_in.phase == etwa_pkg::PH_RESOLVED ||
                            head_in.phase == etwa_pkg::PH_EXPIRED) begin
                            hres.kind = etwa_pkg::KIND_OPENED;
                        end else if (r_sev > head_in.severity) begin
                            hres.kind = etwa_pkg::KIND_ESCALATED;
                        end else if (r_sev < head_in.severity) begin
                            hres.kind = etwa_pkg::KIND_DEESCALATED;
                        end else begin
                            hres.kind = etwa_pkg::KIND_UPDATED;
                        end
                    end else begin
                        head_out.valid    = 1'b1;
                        head_out.key      = r_key;
                        head_out.scope    = r_scope;
                        head_out.revision = 32'd1;
                        hres.kind         = etwa_pkg::KIND_OPENED;
                        hres.created      = 1'b1;
                    end
                end else if (r_clr_en && r_pos == r_clr_idx) begin
                    head_out.valid = 1'b0;
                end
            end
            default: begin
            end
        endcase
        hres.status   = etwa_pkg::ST_OK;
        hres.id       = head_out.key;
        hres.phase    = head_out.phase;
        hres.revision = head_out.revision;
        hres.severity = head_out.severity;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else begin
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= etwa_pkg::S_IDLE;
            r_pos        <= '0;
            r_pend_valid <= 1'b0;
            r_dropped    <= 32'd0;
            r_resolve    <= etwa_pkg::RESOLVE_RESET;
            r_expire     <= etwa_pkg::EXPIRE_RESET;
            r_limit      <= etwa_pkg::LIMIT_RESET;
        end else begin
            r_state <= n_state;
            if (shift) begin
                r_pos <= pos_last ? '0 : r_pos + IW'(1);
            end
            if (cfg_wr) begin
                case (paddr[4:3])
                    etwa_pkg::REG_RESOLVE: r_resolve <= pwdata[47:0];
                    etwa_pkg::REG_EXPIRE:  r_expire  <= pwdata[47:0];
                    etwa_pkg::REG_LIMIT:   r_limit   <= pwdata[5:0];
                    default: begin
                    end
                endcase
            end
            case (r_state)
                etwa_pkg::S_IDLE: begin
                    if (accept) begin
                        r_now        <= i_now;
                        r_key        <= i_episode_key;
                        r_scope      <= i_scope_id;
                        r_sev        <= i_severity;
                        r_pend_valid <= 1'b0;
                        r_nres       <= '0;
                        r_cnt        <= '0;
                        r_hit_found  <= 1'b0;
                        r_vic_found  <= 1'b0;
                        r_free_found <= 1'b0;
                        r_mode       <= i_req_type ? etwa_pkg::M_ADV :
                                        !i_congestion_asserted ? etwa_pkg::M_QUI :
                                        etwa_pkg::M_ASSERT;
                        if (rejected) begin
                            r_o         <= etwa_pkg::error_res((i_scope_id == 16'd0) ?
                                                               etwa_pkg::ST_INVALID :
                                                               etwa_pkg::ST_NO_MECH);
                            r_o_last    <= 1'b1;
                            r_o_dropped <= r_dropped;
                        end
                    end
                end
                etwa_pkg::S_SCAN: begin
                    if (r_mode == etwa_pkg::M_ASSERT) begin
                        if (head_in.valid) begin
                            r_cnt <= r_cnt + CW'(1);
                            if (!r_hit_found && head_in.key == r_key) begin
                                r_hit_found <= 1'b1;
                                r_hit_idx   <= r_pos;
                            end
                            if (head_in.phase[1] &&
                                (!r_vic_found || head_in.updated_at < r_vic_lu)) begin
                                r_vic_found <= 1'b1;
                                r_vic_idx   <= r_pos;
                                r_vic_lu    <= head_in.updated_at;
                            end
                        end else if (!r_free_found) begin
                            r_free_found <= 1'b1;
                            r_free_idx   <= r_pos;
                        end
                    end else if (hres_valid) begin
                        if (r_mode == etwa_pkg::M_ADV) begin
                            r_nres <= r_nres + RW'(1);
                            if (r_pend_valid) begin
                                r_o         <= r_pend;
                                r_o_last    <= 1'b0;
                                r_o_dropped <= r_dropped;
                            end
                            r_pend       <= hres;
                            r_pend_valid <= 1'b1;
                        end else if (!r_pend_valid) begin
                            r_pend       <= hres;
                            r_pend_valid <= 1'b1;
                        end
                    end
                end
                etwa_pkg::S_DECIDE: begin
                    r_tgt_hit <= r_hit_found;
                    r_tgt     <= d_tgt;
                    r_clr_en  <= d_clr_en;
                    r_clr_idx <= r_vic_idx;
                    if (d_drop && r_dropped != 32'hFFFF_FFFF) begin
                        r_dropped <= r_dropped + 32'd1;
                    end
                    if (d_refuse) begin
                        r_pend       <= etwa_pkg::error_res(etwa_pkg::ST_FULL);
                        r_pend_valid <= 1'b1;
                    end
                end
                etwa_pkg::S_APPLY: begin
                    if (hres_valid) begin
                        r_pend       <= hres;
                        r_pend_valid <= 1'b1;
                    end
                end
                etwa_pkg::S_DONE: begin
                    if (r_pend_valid || r_mode != etwa_pkg::M_ADV) begin
                        r_o_last    <= 1'b1;
                        r_o_dropped <= r_dropped;
                        r_o         <= r_pend_valid ? r_pend :
                                       etwa_pkg::error_res(etwa_pkg::ST_OK);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_done            = r_o_valid;
    assign o_status          = r_o.status;
    assign o_update_kind     = r_o.kind;
    assign o_entry_id        = r_o.id;
    assign o_result_phase    = r_o.phase;
    assign o_result_revision = r_o.revision;
    assign o_result_severity = r_o.severity;
    assign o_created         = r_o.created;
    assign o_dropped_total   = r_o_dropped;
    assign o_last_of_run     = r_o_last;

    a_decide_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == etwa_pkg::S_DECIDE |=>
        r_state == etwa_pkg::S_APPLY || r_state == etwa_pkg::S_DONE)
        else $error("decision step did not lead to update pass or result");

    a_ring_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == etwa_pkg::S_IDLE |-> r_pos == '0)
        else $error("slot ring left unaligned while idle");

    a_partial_adv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && !o_last_of_run |-> r_mode == etwa_pkg::M_ADV)
        else $error("non-final item outside an advance");

    a_drop_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != etwa_pkg::S_DECIDE |=> $stable(r_dropped))
        else $error("drop count changed outside the decision step");

endmodule
`default_nettype wire

/* sv/etwa_cell.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// etwa_cell
// One table slot of the rotating ring; takes its neighbor's entry on a shift.
// ----------------------------------------------------------------------------
module etwa_cell (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_shift,
    input  etwa_pkg::t_entry i_entry,
    output etwa_pkg::t_entry o_entry
);

    etwa_pkg::t_entry r_entry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry.valid <= 1'b0;
        end else if (i_shift) begin
            r_entry <= i_entry;
        end
    end

    assign o_entry = r_entry;

endmodule
`default_nettype wire
